// ===== src/ppq_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority print queue package
// Shared types, codes and helpers for the priority print queue blocks.
// ----------------------------------------------------------------------------
package ppq_pkg;

   // Width of the job count carried in every result.
   localparam int CountWidth = 5;

   // Request operations.
   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_CONSULT = 2'd2,
      OP_LIST    = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      BACK_IDLE   = 2'd0,
      BACK_SCAN   = 2'd1,
      BACK_FINISH = 2'd2
   } back_state_type;

   // Request payload as it arrives on the input channel.
   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] job_id;
      logic [15:0] page_count;
      logic [7:0]  job_priority;
   } req_payload_type;

   // Result payload as it leaves on the output channel.
   typedef struct packed {
      status_type            status;
      logic [15:0]           out_id;
      logic [15:0]           out_pages;
      logic [7:0]            out_priority;
      logic [CountWidth-1:0] queue_count;
      logic                  last;
   } rsp_payload_type;

   // One stored job record.
   typedef struct packed {
      logic [15:0] id;
      logic [15:0] pages;
      logic [7:0]  prio;
   } job_rec_type;

   // Decoded command handed from the front end to the back end.
   typedef struct packed {
      op_type      op;
      job_rec_type job;
   } cmd_type;

   // Builds one result from a status, a job record and the job count.
   function automatic rsp_payload_type make_rsp(
      input status_type            status,
      input job_rec_type           job,
      input logic [CountWidth-1:0] count,
      input logic                  last
   );
      rsp_payload_type r;
      r.status       = status;
      r.out_id       = job.id;
      r.out_pages    = job.pages;
      r.out_priority = job.prio;
      r.queue_count  = count;
      r.last         = last;
      return r;
   endfunction

endpackage

// ===== src/ppq_front.sv =====
// ----------------------------------------------------------------------------
// Priority print queue front end
// Accepts requests, decodes them into commands and buffers them in a
// two-entry queue ahead of the back end.
// ----------------------------------------------------------------------------
module ppq_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ppq_pkg::req_payload_type req_payload,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output ppq_pkg::cmd_type         cmd
);

   localparam int Depth = 2;

   ppq_pkg::cmd_type fifo_ff [Depth];
   ppq_pkg::cmd_type cmd_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   // Decode the request into a command.
   always_comb begin
      cmd_in.op       = ppq_pkg::op_type'(req_payload.req_type);
      cmd_in.job.id    = req_payload.job_id;
      cmd_in.job.pages = req_payload.page_count;
      cmd_in.job.prio  = req_payload.job_priority;
   end

   // Queue handshakes.
   assign req_ready = (fill_ff != 2'(Depth));
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = fifo_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // Pointer and fill updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== src/ppq_back.sv =====
// ----------------------------------------------------------------------------
// Priority print queue back end
// Holds the sorted job ring and carries out one command per pass, rotating
// the ring once through all slots while it inserts, removes or reports; an insert into a full queue skips the rotation.
// ----------------------------------------------------------------------------
module ppq_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  ppq_pkg::cmd_type         cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ppq_pkg::rsp_payload_type rsp_payload
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);
   localparam logic [SW-1:0] LastStep  = SW'(QUEUE_DEPTH - 1);

   ppq_pkg::back_state_type  state_ff, state_in;
   ppq_pkg::job_rec_type     slot_ff [QUEUE_DEPTH];
   ppq_pkg::cmd_type         cmd_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic [SW-1:0]            step_ff, step_in;
   logic                     done_ff, done_in;
   ppq_pkg::job_rec_type     hold_ff, hold_in;
   logic                     pend_valid_ff, pend_valid_in;
   ppq_pkg::job_rec_type     pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ppq_pkg::rsp_payload_type rsp_ff, rsp_in;

   ppq_pkg::job_rec_type     head, next_rec, push_rec;
   logic                     head_live, id_hit, out_free, is_full;
   logic                     step_go, shift_en, ahead, hit, match;
   logic                     cmd_take;

   // Views of the ring head and of the command under way.
   assign head      = slot_ff[0];
   assign next_rec  = slot_ff[1];
   assign head_live = (CW'(step_ff) < count_ff);
   assign id_hit    = (head.id == cmd_ff.job.id);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_full   = (count_ff == FullCount);
   assign cmd_take  = cmd_valid && cmd_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppq_pkg::BACK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == ppq_pkg::OP_INSERT && is_full) begin
                  state_in = ppq_pkg::BACK_FINISH;
               end else begin
                  state_in = ppq_pkg::BACK_SCAN;
               end
            end
         end
         ppq_pkg::BACK_SCAN: begin
            if (step_go && step_ff == LastStep) begin
               state_in = ppq_pkg::BACK_FINISH;
            end
         end
         ppq_pkg::BACK_FINISH: begin
            if (out_free) begin
               state_in = ppq_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = ppq_pkg::BACK_IDLE;
         end
      endcase
   end

   // Outputs and datapath for each state.
   always_comb begin
      cmd_ready     = 1'b0;
      step_go       = 1'b0;
      shift_en      = 1'b0;
      ahead         = 1'b0;
      hit           = 1'b0;
      match         = 1'b0;
      push_rec      = head;
      step_in       = step_ff;
      done_in       = done_ff;
      hold_in       = hold_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ppq_pkg::BACK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               step_in       = '0;
               done_in       = 1'b0;
               pend_valid_in = 1'b0;
            end
         end
         ppq_pkg::BACK_SCAN: begin
            unique case (cmd_ff.op)
               ppq_pkg::OP_INSERT: begin
                  // The new job goes ahead of the first entry that is not
                  // higher, or right after the last live entry.
                  ahead   = !done_ff && (!head_live || cmd_ff.job.prio >= head.prio);
                  step_go = 1'b1;
                  if (ahead) begin
                     push_rec = cmd_ff.job;
                  end else if (done_ff) begin
                     push_rec = hold_ff;
                  end
                  if (ahead || done_ff) begin
                     hold_in = head;
                  end
                  done_in = done_ff || ahead;
               end
               ppq_pkg::OP_REMOVE: begin
                  // From the hit on, the ring closes up by taking the next slot.
                  hit     = !done_ff && head_live && id_hit;
                  step_go = 1'b1;
                  if (done_ff || hit) begin
                     push_rec = next_rec;
                  end
                  if (hit) begin
                     hold_in = head;
                  end
                  done_in = done_ff || hit;
               end
               ppq_pkg::OP_CONSULT, ppq_pkg::OP_LIST: begin
                  // One matching entry is held back so that the final one
                  // can carry the last flag.
                  match   = head_live && (cmd_ff.op == ppq_pkg::OP_LIST || id_hit);
                  step_go = !(match && pend_valid_ff && !out_free);
                  if (step_go && match) begin
                     pend_in       = head;
                     pend_valid_in = 1'b1;
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_OK, pend_ff,
                           ppq_pkg::CountWidth'(count_ff), 1'b0);
                     end
                  end
               end
               default: begin
                  step_go = 1'b1;
               end
            endcase
            if (step_go) begin
               shift_en = 1'b1;
               step_in  = step_ff + 1'b1;
            end
         end
         ppq_pkg::BACK_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               unique case (cmd_ff.op)
                  ppq_pkg::OP_INSERT: begin
                     if (is_full) begin
                        rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_FULL, '0,
                           ppq_pkg::CountWidth'(count_ff), 1'b1);
                     end else begin
                        count_in = count_ff + 1'b1;
                        rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_OK, cmd_ff.job,
                           ppq_pkg::CountWidth'(count_in), 1'b1);
                     end
                  end
                  ppq_pkg::OP_REMOVE: begin
                     if (done_ff) begin
                        count_in = count_ff - 1'b1;
                        rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_OK, hold_ff,
                           ppq_pkg::CountWidth'(count_in), 1'b1);
                     end else begin
                        rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_NOT_FOUND, '0,
                           ppq_pkg::CountWidth'(count_ff), 1'b1);
                     end
                  end
                  ppq_pkg::OP_CONSULT: begin
                     if (pend_valid_ff) begin
                        rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_OK, pend_ff,
                           ppq_pkg::CountWidth'(count_ff), 1'b1);
                     end else begin
                        rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_NOT_FOUND, '0,
                           ppq_pkg::CountWidth'(count_ff), 1'b1);
                     end
                  end
                  ppq_pkg::OP_LIST: begin
                     if (pend_valid_ff) begin
                        rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_OK, pend_ff,
                           ppq_pkg::CountWidth'(count_ff), 1'b1);
                     end else begin
                        rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_EMPTY, '0,
                           ppq_pkg::CountWidth'(count_ff), 1'b1);
                     end
                  end
                  default: begin
                     rsp_in = ppq_pkg::make_rsp(ppq_pkg::ST_EMPTY, '0,
                        ppq_pkg::CountWidth'(count_ff), 1'b1);
                  end
               endcase
            end
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ppq_pkg::BACK_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         done_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         done_ff       <= done_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (cmd_take) begin
         cmd_ff <= cmd;
      end
   end

   // Job ring: pops at the head and refills at the tail on every scan step.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            slot_ff[i] <= slot_ff[i + 1];
         end
         slot_ff[QUEUE_DEPTH - 1] <= push_rec;
      end
   end

endmodule

// ===== src/priority_print_queue_top.sv =====
// ----------------------------------------------------------------------------
// Priority print queue top level
// Bounded job queue kept in descending priority order, with insert, remove,
// consult and list requests.
// ----------------------------------------------------------------------------
// A request is taken into a two-entry queue and then handled by a back end
// that rotates its ring of QUEUE_DEPTH job slots once per request, one slot
// each cycle unless the scan pauses; an insert into a full queue skips the
// rotation. A consult or list may emit up to QUEUE_DEPTH results, and the
// scan pauses on a match while the result register is still held.
// Every result carries the job count after the request, and the final
// result of a request has last set.
module priority_print_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ppq_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ppq_pkg::rsp_payload_type rsp_payload
);

   logic             cmd_valid;
   logic             cmd_ready;
   ppq_pkg::cmd_type cmd;

   // Request intake and decode.
   ppq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   // Job ring and result generation.
   ppq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/tb_priority_print_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority print queue testbench
// Drives insert, remove, consult and list requests into the job queue. A
// short table of requests covers the empty and full queue, extreme field
// values and equal priorities. Random requests follow in alternating fill
// and drain stretches. Every result is compared field by field with a
// typed-in result or with a sorted-list model of the queue kept here.
// ----------------------------------------------------------------------------
module tb_priority_print_queue_top;
   import ppq_pkg::*;

   localparam int QueueDepth   = 16;
   localparam int RandomItems  = 155;
   localparam int StretchItems = 30;
   localparam int HoldCycles   = 300;
   localparam int CycleLimit   = 400000;

   // One row of the directed table, with an optional typed-in result.
   typedef struct {
      req_payload_type req;
      bit              fixed;
      rsp_payload_type rsp;
   } dir_row_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   // Model of the queue contents, highest priority in slot zero.
   job_rec_type     model_jobs[QueueDepth];
   int unsigned     model_count;
   rsp_payload_type step_results[$];
   rsp_payload_type awaited_rsps[$];

   int unsigned     tx_idle_pct;
   int unsigned     rx_idle_pct;
   int unsigned     rsp_hold_left;
   int unsigned     error_count;
   int unsigned     cycle_count;

   priority_print_queue_top #(
      .QUEUE_DEPTH(QueueDepth)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Appends one expected result carrying the current job count.
   function automatic void note_result(input status_type st, input job_rec_type job);
      rsp_payload_type r;
      r.status       = st;
      r.out_id       = job.id;
      r.out_pages    = job.pages;
      r.out_priority = job.prio;
      r.queue_count  = CountWidth'(model_count);
      r.last         = 1'b0;
      step_results.push_back(r);
   endfunction

   // Applies one request to the queue model and collects its results.
   function automatic void apply_to_job_queue(input req_payload_type p);
      job_rec_type     nj;
      job_rec_type     gone;
      rsp_payload_type tail;
      int unsigned     pos;
      op_type          op;
      nj.id    = p.job_id;
      nj.pages = p.page_count;
      nj.prio  = p.job_priority;
      op       = op_type'(p.req_type);
      step_results.delete();
      case (op)
         OP_INSERT: begin
            if (model_count >= QueueDepth) begin
               note_result(ST_FULL, '0);
            end else begin
               pos = 0;
               while (pos < model_count && nj.prio < model_jobs[pos].prio) pos++;
               for (int unsigned i = model_count; i > pos; i--) begin
                  model_jobs[i] = model_jobs[i-1];
               end
               model_jobs[pos] = nj;
               model_count++;
               note_result(ST_OK, nj);
            end
         end
         OP_REMOVE: begin
            pos = 0;
            while (pos < model_count && model_jobs[pos].id != nj.id) pos++;
            if (pos >= model_count) begin
               note_result(ST_NOT_FOUND, '0);
            end else begin
               gone = model_jobs[pos];
               for (int unsigned i = pos; i + 1 < model_count; i++) begin
                  model_jobs[i] = model_jobs[i+1];
               end
               model_count--;
               note_result(ST_OK, gone);
            end
         end
         OP_CONSULT: begin
            for (int unsigned i = 0; i < model_count; i++) begin
               if (model_jobs[i].id == nj.id) note_result(ST_OK, model_jobs[i]);
            end
            if (step_results.size() == 0) note_result(ST_NOT_FOUND, '0);
         end
         default: begin
            for (int unsigned i = 0; i < model_count; i++) begin
               note_result(ST_OK, model_jobs[i]);
            end
            if (step_results.size() == 0) note_result(ST_EMPTY, '0);
         end
      endcase
      // Only the final result of a request is marked.
      tail      = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
   endfunction

   function automatic dir_row_type dir_row(input op_type op, input logic [15:0] id,
                                           input logic [15:0] pages, input logic [7:0] prio,
                                           input bit fixed, input rsp_payload_type rsp);
      dir_row_type row;
      row.req.req_type     = op;
      row.req.job_id       = id;
      row.req.page_count   = pages;
      row.req.job_priority = prio;
      row.fixed            = fixed;
      row.rsp              = rsp;
      return row;
   endfunction

   // Random request; a fill stretch leans on inserts, a drain stretch on
   // removes, which mostly name jobs that are actually held.
   function automatic req_payload_type random_request(input bit filling);
      req_payload_type p;
      int unsigned     pick;
      int unsigned     id_pick;
      pick           = $urandom_range(99);
      id_pick        = $urandom_range(99);
      p.page_count   = 16'($urandom_range(65535));
      p.job_priority = ($urandom_range(1) == 1) ? 8'($urandom_range(3) * 85)
                                                : 8'($urandom_range(255));
      if (pick < (filling ? 65 : 10)) p.req_type = OP_INSERT;
      else if (pick < 75)             p.req_type = OP_REMOVE;
      else if (pick < 88)             p.req_type = OP_CONSULT;
      else                            p.req_type = OP_LIST;
      if (p.req_type != OP_INSERT && id_pick < 60 && model_count > 0) begin
         p.job_id = model_jobs[$urandom_range(model_count - 1)].id;
      end else if (id_pick < 85) begin
         p.job_id = 16'($urandom_range(7));
      end else begin
         p.job_id = 16'($urandom_range(65535));
      end
      return p;
   endfunction

   // Offers one request, waits for it to be taken and records its results.
   task automatic offer_request(input req_payload_type p, input bit fixed,
                                input rsp_payload_type fixed_rsp);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      apply_to_job_queue(p);
      if (fixed) begin
         awaited_rsps.push_back(fixed_rsp);
      end else begin
         foreach (step_results[i]) awaited_rsps.push_back(step_results[i]);
      end
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   // Result side: random ready, with one long hold-off when requested.
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
         @(posedge clock);
      end
   end

   // Result checker.
   initial begin
      rsp_payload_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
               $error("unexpected result: status %0d id %0h", rsp_payload.status,
                      rsp_payload.out_id);
               error_count++;
            end else begin
               want = awaited_rsps.pop_front();
               check_field("status", want.status, rsp_payload.status);
               check_field("out_id", want.out_id, rsp_payload.out_id);
               check_field("out_pages", want.out_pages, rsp_payload.out_pages);
               check_field("out_priority", want.out_priority, rsp_payload.out_priority);
               check_field("queue_count", want.queue_count, rsp_payload.queue_count);
               check_field("last", want.last, rsp_payload.last);
            end
         end
      end
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("run did not finish within %0d cycles", CycleLimit);
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus.
   initial begin
      dir_row_type dir_table[$];
      bit          filling;
      model_count   = 0;
      error_count   = 0;
      rsp_hold_left = 0;
      tx_idle_pct   = 12;
      rx_idle_pct   = 87;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;

      // Empty queue, extreme fields, equal priorities, then fill to the top.
      dir_table.push_back(dir_row(OP_LIST, 16'h0, 16'h0, 8'h0, 1'b1,
         rsp_payload_type'{ST_EMPTY, 16'h0, 16'h0, 8'h0, 5'd0, 1'b1}));
      dir_table.push_back(dir_row(OP_REMOVE, 16'h0005, 16'h0, 8'h0, 1'b1,
         rsp_payload_type'{ST_NOT_FOUND, 16'h0, 16'h0, 8'h0, 5'd0, 1'b1}));
      dir_table.push_back(dir_row(OP_CONSULT, 16'h0005, 16'hFFFF, 8'hFF, 1'b1,
         rsp_payload_type'{ST_NOT_FOUND, 16'h0, 16'h0, 8'h0, 5'd0, 1'b1}));
      dir_table.push_back(dir_row(OP_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
         rsp_payload_type'{ST_OK, 16'hFFFF, 16'hFFFF, 8'hFF, 5'd1, 1'b1}));
      dir_table.push_back(dir_row(OP_INSERT, 16'h0000, 16'h0000, 8'h00, 1'b1,
         rsp_payload_type'{ST_OK, 16'h0, 16'h0, 8'h0, 5'd2, 1'b1}));
      dir_table.push_back(dir_row(OP_INSERT, 16'h0007, 16'h1234, 8'h80, 1'b0, '0));
      dir_table.push_back(dir_row(OP_INSERT, 16'h0007, 16'h5678, 8'h80, 1'b0, '0));
      dir_table.push_back(dir_row(OP_CONSULT, 16'h0007, 16'h0, 8'h0, 1'b0, '0));
      dir_table.push_back(dir_row(OP_REMOVE, 16'h0007, 16'h0, 8'h0, 1'b0, '0));
      dir_table.push_back(dir_row(OP_REMOVE, 16'h1234, 16'h0, 8'h0, 1'b1,
         rsp_payload_type'{ST_NOT_FOUND, 16'h0, 16'h0, 8'h0, 5'd3, 1'b1}));
      for (int k = 0; k < QueueDepth - 3; k++) begin
         dir_table.push_back(dir_row(OP_INSERT, 16'(16'h0100 + k), 16'(k * 16'h1111),
                                     8'((k % 4) * 85), 1'b0, '0));
      end
      dir_table.push_back(dir_row(OP_INSERT, 16'h00AA, 16'h00AA, 8'h55, 1'b1,
         rsp_payload_type'{ST_FULL, 16'h0, 16'h0, 8'h0, 5'd16, 1'b1}));
      dir_table.push_back(dir_row(OP_LIST, 16'h0, 16'h0, 8'h0, 1'b0, '0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) offer_request(dir_table[i].req, dir_table[i].fixed,
                                           dir_table[i].rsp);

      // Random part; the queue is full here, so start by draining.
      filling = 1'b0;
      for (int k = 0; k < RandomItems; k++) begin
         if (k == RandomItems / 3) begin
            tx_idle_pct = 87;
            rx_idle_pct = 12;
         end else if (k == 2 * RandomItems / 3) begin
            tx_idle_pct   = 0;
            rx_idle_pct   = 0;
            rsp_hold_left = HoldCycles;
         end
         if (k % StretchItems == 0 && k != 0) filling = !filling;
         offer_request(random_request(filling), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Drain the outstanding results, then watch for stray ones.
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (4 * (QueueDepth + 2)) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/ppq_pkg.sv
src/ppq_front.sv
src/ppq_back.sv
src/priority_print_queue_top.sv
tb/tb_priority_print_queue_top.sv
